@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top level of the packet receiver.
// Depends on nothing; each macro wraps one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fprc8_pkg.sv @@
// Package for the framed packet receiver: header bytes, event codes,
// register map and the byte-wide CRC-8 update. Depends on nothing.
package fprc8_pkg;

	localparam int COUNTER_WIDTH = 16;
	localparam int APB_DATA_W    = 32;
	localparam int APB_ADDR_W    = 5;

	localparam logic [7:0] HDR_FIRST  = 8'h06;
	localparam logic [7:0] HDR_SECOND = 8'h85;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_DATA    = 3'd1;
	localparam logic [2:0] EV_GOOD    = 3'd2;
	localparam logic [2:0] EV_CRCBAD  = 3'd3;
	localparam logic [2:0] EV_DESTBAD = 3'd4;
	localparam logic [2:0] EV_JUNK    = 3'd5;

	// Register index, taken from paddr[4:2].
	localparam logic [2:0] REG_CRC_POLY   = 3'd0;
	localparam logic [2:0] REG_LOW_DEST   = 3'd1;
	localparam logic [2:0] REG_HIGH_DEST  = 3'd2;
	localparam logic [2:0] REG_ALIGN_CNT  = 3'd3;
	localparam logic [2:0] REG_CRCERR_CNT = 3'd4;
	localparam logic [2:0] REG_DESTERR_CNT = 3'd5;

	localparam logic [7:0] RST_CRC_POLY  = 8'd140;
	localparam logic [7:0] RST_LOW_DEST  = 8'd1;
	localparam logic [7:0] RST_HIGH_DEST = 8'd6;

	// LSB-first CRC-8 update over one byte, eight bit steps of xor logic.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data,
		input logic [7:0] poly);
		logic [7:0] crc;
		logic [7:0] d;
		logic       fb;
		crc = crc_in;
		d   = data;
		for (int i = 0; i < 8; i++) begin
			fb  = crc[0] ^ d[0];
			crc = {1'b0, crc[7:1]};
			if (fb) begin
				crc = crc ^ poly;
			end
			d = {1'b0, d[7:1]};
		end
		return crc;
	endfunction

endpackage

@@ rtl/framed_packet_receiver_crc8_top.sv @@
// Framed packet receiver with CRC-8 check: one received byte in, one event out per transaction.
// A byte's event is registered and appears in the cycle after the byte is accepted.
// One byte per cycle if not stalled; parser state and CRC update in a single registered pass.
// Reset: arst_n clears parser state, counters, registers to defaults and the output valid flag.
// Depends on fprc8_pkg and assert_macros.svh.
`include "assert_macros.svh"

module framed_packet_receiver_crc8_top #(
	parameter int COUNTER_WIDTH = fprc8_pkg::COUNTER_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input byte stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,  // [7:0] rx_byte
	// Event stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,  // [2:0] event_res, [7:3] zero
	// APB configuration and status port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fprc8_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [fprc8_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [fprc8_pkg::APB_DATA_W-1:0]   prdata,
	output logic                               pready
);

	// Parser phases. The skip phase swallows length+1 bytes after a rejected destination.
	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_DEST,
		PH_SRC,
		PH_LEN,
		PH_DATA,
		PH_CRC,
		PH_SKIP
	} phase_t;

	// Configuration registers.
	logic [7:0] crc_poly_q;
	logic [7:0] low_dest_q;
	logic [7:0] high_dest_q;

	// Parser state.
	phase_t     phase_q;
	logic [7:0] dest_addr_q;
	logic [7:0] src_addr_q;
	logic [7:0] pay_len_q;
	logic [7:0] bytes_seen_q;
	logic [7:0] crc_q;
	logic [8:0] skip_q;

	// Wrapping error counters, readable over APB.
	logic [COUNTER_WIDTH-1:0] align_cnt_q;
	logic [COUNTER_WIDTH-1:0] crcerr_cnt_q;
	logic [COUNTER_WIDTH-1:0] desterr_cnt_q;

	// Output register.
	logic       m_tvalid_q;
	logic [2:0] event_q;

	// Next-state values from the single combinational pass.
	phase_t     phase_d;
	logic [7:0] dest_addr_d;
	logic [7:0] src_addr_d;
	logic [7:0] pay_len_d;
	logic [7:0] bytes_seen_d;
	logic [7:0] crc_d;
	logic [8:0] skip_d;
	logic [2:0] event_d;
	logic       inc_align;
	logic       inc_crcerr;
	logic       inc_desterr;

	logic       s_accept;
	logic       cfg_write;
	logic [2:0] reg_idx;
	logic [7:0] seen_inc;
	logic [8:0] skip_dec;
	logic       dest_bad;

	// The output register parts the two sides: a new byte is taken while the
	// pending event is being handed over in the same cycle.
	assign s_tready  = !m_tvalid_q || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {5'b0, event_q};

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[fprc8_pkg::APB_ADDR_W-1:2];

	assign seen_inc  = bytes_seen_q + 8'd1;
	assign skip_dec  = (skip_q != 9'd0) ? (skip_q - 9'd1) : skip_q;
	assign dest_bad  = (dest_addr_q < low_dest_q) || (dest_addr_q > high_dest_q);

	always_comb begin
		phase_d      = phase_q;
		dest_addr_d  = dest_addr_q;
		src_addr_d   = src_addr_q;
		pay_len_d    = pay_len_q;
		bytes_seen_d = bytes_seen_q;
		crc_d        = crc_q;
		skip_d       = skip_q;
		event_d      = fprc8_pkg::EV_NONE;
		inc_align    = 1'b0;
		inc_crcerr   = 1'b0;
		inc_desterr  = 1'b0;
		case (phase_q)
			PH_HUNT1: begin
				if (s_tdata == fprc8_pkg::HDR_FIRST) begin
					phase_d = PH_HUNT2;
				end else begin
					inc_align = 1'b1;
					event_d   = fprc8_pkg::EV_JUNK;
				end
			end
			PH_HUNT2: begin
				// A wrong second header byte sends the parser back to hunting
				// without counting it as misalignment.
				if (s_tdata == fprc8_pkg::HDR_SECOND) begin
					phase_d = PH_DEST;
				end else begin
					phase_d = PH_HUNT1;
					event_d = fprc8_pkg::EV_JUNK;
				end
			end
			PH_DEST: begin
				dest_addr_d = s_tdata;
				phase_d     = PH_SRC;
			end
			PH_SRC: begin
				src_addr_d = s_tdata;
				phase_d    = PH_LEN;
			end
			PH_LEN: begin
				// The destination is judged here, once the length is known.
				pay_len_d = s_tdata;
				if (dest_bad) begin
					inc_desterr = 1'b1;
					skip_d      = {1'b0, s_tdata} + 9'd1;
					phase_d     = PH_SKIP;
					event_d     = fprc8_pkg::EV_DESTBAD;
				end else if (s_tdata == 8'd0) begin
					phase_d = PH_HUNT1;
				end else begin
					bytes_seen_d = 8'd0;
					crc_d        = 8'd0;
					phase_d      = PH_DATA;
				end
			end
			PH_DATA: begin
				crc_d        = fprc8_pkg::crc8_byte(crc_q, s_tdata, crc_poly_q);
				bytes_seen_d = seen_inc;
				event_d      = fprc8_pkg::EV_DATA;
				if (seen_inc >= pay_len_q) begin
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				if (s_tdata == crc_q) begin
					event_d = fprc8_pkg::EV_GOOD;
				end else begin
					inc_crcerr = 1'b1;
					event_d    = fprc8_pkg::EV_CRCBAD;
				end
				phase_d = PH_HUNT1;
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 9'd0) begin
					phase_d = PH_HUNT1;
				end
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

	// Parser state, counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT1;
			dest_addr_q   <= 8'd0;
			src_addr_q    <= 8'd0;
			pay_len_q     <= 8'd0;
			bytes_seen_q  <= 8'd0;
			crc_q         <= 8'd0;
			skip_q        <= 9'd0;
			align_cnt_q   <= '0;
			crcerr_cnt_q  <= '0;
			desterr_cnt_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (s_accept) begin
				phase_q      <= phase_d;
				dest_addr_q  <= dest_addr_d;
				src_addr_q   <= src_addr_d;
				pay_len_q    <= pay_len_d;
				bytes_seen_q <= bytes_seen_d;
				crc_q        <= crc_d;
				skip_q       <= skip_d;
				if (inc_align) begin
					align_cnt_q <= align_cnt_q + 1'b1;
				end
				if (inc_crcerr) begin
					crcerr_cnt_q <= crcerr_cnt_q + 1'b1;
				end
				if (inc_desterr) begin
					desterr_cnt_q <= desterr_cnt_q + 1'b1;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// The event payload needs no reset; it is qualified by m_tvalid_q.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			event_q <= event_d;
		end
	end

	// Configuration registers. Writes to status or unused addresses are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q  <= fprc8_pkg::RST_CRC_POLY;
			low_dest_q  <= fprc8_pkg::RST_LOW_DEST;
			high_dest_q <= fprc8_pkg::RST_HIGH_DEST;
		end else if (cfg_write) begin
			case (reg_idx)
				fprc8_pkg::REG_CRC_POLY:  crc_poly_q  <= pwdata[7:0];
				fprc8_pkg::REG_LOW_DEST:  low_dest_q  <= pwdata[7:0];
				fprc8_pkg::REG_HIGH_DEST: high_dest_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Read mux: the three settings, then the three error counters.
	always_comb begin
		case (reg_idx)
			fprc8_pkg::REG_CRC_POLY:    prdata = {24'd0, crc_poly_q};
			fprc8_pkg::REG_LOW_DEST:    prdata = {24'd0, low_dest_q};
			fprc8_pkg::REG_HIGH_DEST:   prdata = {24'd0, high_dest_q};
			fprc8_pkg::REG_ALIGN_CNT:   prdata = fprc8_pkg::APB_DATA_W'(align_cnt_q);
			fprc8_pkg::REG_CRCERR_CNT:  prdata = fprc8_pkg::APB_DATA_W'(crcerr_cnt_q);
			fprc8_pkg::REG_DESTERR_CNT: prdata = fprc8_pkg::APB_DATA_W'(desterr_cnt_q);
			default:                    prdata = '0;
		endcase
	end

	// The skip phase is always entered with a nonzero count and leaves as it reaches zero.
	`ASSERT_CLK(a_skip_nonzero, clk, arst_n,
		(phase_q != PH_SKIP) || (skip_q != 9'd0), "skip phase with zero count")
	// A byte taken in the payload phase always reports as a payload byte.
	`ASSERT_NEXT(a_data_event, clk, arst_n, s_accept && (phase_q == PH_DATA),
		m_tvalid && (m_tdata[2:0] == fprc8_pkg::EV_DATA), "payload byte not reported")
	// The input side stalls only while an event waits to be taken.
	`ASSERT_CLK(a_ready_stall, clk, arst_n,
		s_tready || (m_tvalid && !m_tready), "input stalled without pending event")

endmodule

@@ sim/framed_packet_receiver_crc8_top_test.sv @@
// Self-checking testbench for framed_packet_receiver_crc8_top: byte stream in, event stream out.
// Depends on fprc8_pkg and the RTL top level; predicts every event and checks the APB registers.
`timescale 1ns / 1ps

module framed_packet_receiver_crc8_top_test;
	import fprc8_pkg::*;

	localparam int CW          = fprc8_pkg::COUNTER_WIDTH;
	localparam int CYCLE_LIMIT = 2000000;

	// Parser phases of the predictor, in the order a packet walks through them.
	typedef enum logic [2:0] {
		WAIT_SYNC0, WAIT_SYNC1, TAKE_DEST, TAKE_SRC, TAKE_LEN, TAKE_PAYLOAD, TAKE_CRC, DROP_BODY
	} parse_phase_e;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr  = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic        pready;

	framed_packet_receiver_crc8_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// Bytes still to be offered to the block, and the events the block owes us.
	logic [7:0] rx_bytes_q[$];
	logic [2:0] event_q[$];

	// Shadow of the configuration registers as the block should hold them.
	logic [7:0] cfg_poly = RST_CRC_POLY;
	logic [7:0] cfg_low  = RST_LOW_DEST;
	logic [7:0] cfg_high = RST_HIGH_DEST;

	// Predicted parser state and error counters.
	parse_phase_e  pphase    = WAIT_SYNC0;
	logic [7:0]    p_dest    = '0;
	logic [7:0]    p_len     = '0;
	logic [7:0]    p_seen    = '0;
	logic [7:0]    p_crc     = '0;
	logic [8:0]    p_skip    = '0;
	logic [CW-1:0] cnt_align = '0;
	logic [CW-1:0] cnt_crc   = '0;
	logic [CW-1:0] cnt_dest  = '0;

	int  mismatches = 0;
	int  cycles     = 0;
	bit  idle_on    = 1'b0;
	int  gap_left   = 0;
	int  stall_left = 0;

	task automatic note_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch: %s expected %0h actual %0h", what, want, got);
		end
	endtask

	// One byte through the reflected CRC-8, least significant bit first.
	function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		logic       out_bit;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			out_bit = c[0] ^ b[k];
			c = c >> 1;
			if (out_bit) begin
				c = c ^ poly;
			end
		end
		return c;
	endfunction

	// Advances the predicted parser by one received byte and returns the event it causes.
	function automatic logic [2:0] parse_byte(input logic [7:0] b);
		logic [2:0] ev;
		ev = EV_NONE;
		case (pphase)
			WAIT_SYNC0: begin
				if (b == HDR_FIRST) begin
					pphase = WAIT_SYNC1;
				end else begin
					cnt_align = cnt_align + 1'b1;
					ev = EV_JUNK;
				end
			end
			WAIT_SYNC1: begin
				// A wrong second header byte is discarded without counting; the
				// byte after it starts a fresh hunt.
				if (b == HDR_SECOND) begin
					pphase = TAKE_DEST;
				end else begin
					pphase = WAIT_SYNC0;
					ev = EV_JUNK;
				end
			end
			TAKE_DEST: begin
				p_dest = b;
				pphase = TAKE_SRC;
			end
			TAKE_SRC: pphase = TAKE_LEN;
			TAKE_LEN: begin
				p_len = b;
				if (p_dest < cfg_low || p_dest > cfg_high) begin
					cnt_dest = cnt_dest + 1'b1;
					p_skip = {1'b0, b} + 9'd1;
					pphase = DROP_BODY;
					ev = EV_DESTBAD;
				end else if (b == 8'h00) begin
					pphase = WAIT_SYNC0;
				end else begin
					p_seen = '0;
					p_crc = '0;
					pphase = TAKE_PAYLOAD;
				end
			end
			TAKE_PAYLOAD: begin
				p_crc = crc_update(p_crc, b, cfg_poly);
				p_seen = p_seen + 1'b1;
				ev = EV_DATA;
				if (p_seen >= p_len) begin
					pphase = TAKE_CRC;
				end
			end
			TAKE_CRC: begin
				if (b == p_crc) begin
					ev = EV_GOOD;
				end else begin
					cnt_crc = cnt_crc + 1'b1;
					ev = EV_CRCBAD;
				end
				pphase = WAIT_SYNC0;
			end
			default: begin
				if (p_skip != 0) begin
					p_skip = p_skip - 1'b1;
				end
				if (p_skip == 0) begin
					pphase = WAIT_SYNC0;
				end
			end
		endcase
		return ev;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	// Sender: offers queued bytes, predicting each one's event at the edge it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				event_q.push_back(parse_byte(s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (rx_bytes_q.size() != 0) begin
					s_tdata  <= rx_bytes_q.pop_front();
					s_tvalid <= 1'b1;
					gap_left <= (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every event transaction against the oldest prediction and
	// throttles m_tready at random while idling is enabled.
	always @(posedge clk) begin : event_monitor
		logic [2:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (event_q.size() == 0) begin
					note_mismatch("event with none predicted", 32'h0, {24'h0, m_tdata});
				end else begin
					want = event_q.pop_front();
					if (m_tdata != {5'b00000, want}) begin
						note_mismatch("event", {29'h0, want}, {24'h0, m_tdata});
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 4) == 0) begin
					stall_left <= pick_gap();
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_access(input logic [2:0] idx, input bit is_write,
		input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes all three configuration registers; the upper data bits carry noise
	// that the block must drop.
	task automatic apply_config(input logic [7:0] poly, input logic [7:0] lo,
		input logic [7:0] hi);
		logic [APB_DATA_W-1:0] unused;
		apb_access(REG_CRC_POLY, 1'b1, {24'($urandom), poly}, unused);
		cfg_poly = poly;
		apb_access(REG_LOW_DEST, 1'b1, {24'($urandom), lo}, unused);
		cfg_low = lo;
		apb_access(REG_HIGH_DEST, 1'b1, {24'($urandom), hi}, unused);
		cfg_high = hi;
	endtask

	// Reads back the configuration and the three wrapping error counters.
	task automatic check_registers();
		logic [APB_DATA_W-1:0] rd;
		logic [APB_DATA_W-1:0] wr;
		wr = '0;
		apb_access(REG_CRC_POLY, 1'b0, wr, rd);
		if (rd[7:0] != cfg_poly) note_mismatch("crc polynomial", 32'(cfg_poly), 32'(rd[7:0]));
		apb_access(REG_LOW_DEST, 1'b0, wr, rd);
		if (rd[7:0] != cfg_low) note_mismatch("lowest destination", 32'(cfg_low),
			32'(rd[7:0]));
		apb_access(REG_HIGH_DEST, 1'b0, wr, rd);
		if (rd[7:0] != cfg_high) note_mismatch("highest destination", 32'(cfg_high),
			32'(rd[7:0]));
		apb_access(REG_ALIGN_CNT, 1'b0, wr, rd);
		if (rd[CW-1:0] != cnt_align) note_mismatch("align count", 32'(cnt_align),
			32'(rd[CW-1:0]));
		apb_access(REG_CRCERR_CNT, 1'b0, wr, rd);
		if (rd[CW-1:0] != cnt_crc) note_mismatch("crc error count", 32'(cnt_crc),
			32'(rd[CW-1:0]));
		apb_access(REG_DESTERR_CNT, 1'b0, wr, rd);
		if (rd[CW-1:0] != cnt_dest) note_mismatch("destination error count", 32'(cnt_dest),
			32'(rd[CW-1:0]));
	endtask

	// Queues a whole packet: header, addresses, length, random payload and CRC
	// computed with the current polynomial, optionally corrupted.
	task automatic queue_packet(input logic [7:0] dest, input logic [7:0] src,
		input logic [7:0] len, input bit bad_crc);
		logic [7:0] crc;
		logic [7:0] b;
		crc = '0;
		rx_bytes_q.push_back(HDR_FIRST);
		rx_bytes_q.push_back(HDR_SECOND);
		rx_bytes_q.push_back(dest);
		rx_bytes_q.push_back(src);
		rx_bytes_q.push_back(len);
		for (int k = 0; k < len; k++) begin
			b = 8'($urandom_range(0, 255));
			crc = crc_update(crc, b, cfg_poly);
			rx_bytes_q.push_back(b);
		end
		if (bad_crc) begin
			crc = crc ^ 8'($urandom_range(1, 255));
		end
		rx_bytes_q.push_back(crc);
	endtask

	// Fills about n bytes of mostly well-formed packets mixed with noise, lets the
	// block run until every event has come back, then checks the registers.
	task automatic run_phase(input int n, input bit gaps);
		int         r;
		int         cnt;
		logic [7:0] dest;
		logic [7:0] len;
		idle_on = gaps;
		while (rx_bytes_q.size() < n) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				cnt = $urandom_range(1, 4);
				repeat (cnt) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
			end else if (r < 18) begin
				// First header byte followed by whatever: mostly a broken header.
				rx_bytes_q.push_back(HDR_FIRST);
				rx_bytes_q.push_back(8'($urandom_range(0, 255)));
			end else if (r < 23) begin
				// Packet cut short; the next packet's bytes land in its fields.
				rx_bytes_q.push_back(HDR_FIRST);
				rx_bytes_q.push_back(HDR_SECOND);
				cnt = $urandom_range(0, 3);
				repeat (cnt) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				if (cfg_low <= cfg_high && $urandom_range(0, 9) < 7) begin
					dest = 8'($urandom_range(cfg_high, cfg_low));
				end else begin
					dest = 8'($urandom_range(0, 255));
				end
				r = $urandom_range(0, 999);
				if (r < 4) begin
					len = 8'hFF;
				end else if (r < 10) begin
					len = 8'($urandom_range(128, 254));
				end else if (r < 250) begin
					len = 8'($urandom_range(13, 40));
				end else begin
					len = 8'($urandom_range(0, 12));
				end
				queue_packet(dest, 8'($urandom_range(0, 255)), len,
					$urandom_range(0, 4) == 0);
			end
		end
		// Hold further traffic until the block has answered everything; the
		// check runs between edges so that every update of the edge has landed.
		while (rx_bytes_q.size() != 0 || s_tvalid || event_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(posedge clk);
		check_registers();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed opening under the reset configuration: junk, a wrong second
		// header byte, then a stray second header byte while hunting.
		rx_bytes_q.push_back(8'hFF);
		rx_bytes_q.push_back(HDR_FIRST);
		rx_bytes_q.push_back(HDR_FIRST);
		rx_bytes_q.push_back(HDR_SECOND);
		// Zero length to an accepted destination: its CRC byte is hunted as junk.
		queue_packet(8'd1, 8'hFF, 8'd0, 1'b0);
		// Good packet at the top of the range, then one just above it.
		queue_packet(8'd6, 8'h00, 8'd1, 1'b0);
		queue_packet(8'd7, 8'h5A, 8'd0, 1'b0);
		// CRC failure.
		queue_packet(8'd3, 8'hA5, 8'd1, 1'b1);
		run_phase(280, 1'b1);

		// Every destination accepted, zero polynomial, no idling at all.
		apply_config(8'h00, 8'h00, 8'hFF);
		run_phase(280, 1'b0);

		// Single accepted destination at the top, all-ones polynomial.
		apply_config(8'hFF, 8'hFF, 8'hFF);
		run_phase(280, 1'b1);

		// Empty range: every destination is rejected.
		apply_config(8'h8C, 8'd200, 8'd10);
		run_phase(280, 1'b1);

		// Single accepted destination at the bottom.
		apply_config(8'h07, 8'h00, 8'h00);
		run_phase(280, 1'b0);

		apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 127)),
			8'($urandom_range(64, 255)));
		run_phase(280, 1'b1);

		apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		run_phase(280, 1'b1);

		repeat (5) @(posedge clk);
		if (event_q.size() != 0) begin
			note_mismatch("events never delivered", 32'h0, event_q.size());
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ framed_packet_receiver_crc8_top.f @@
+incdir+rtl
rtl/fprc8_pkg.sv
rtl/framed_packet_receiver_crc8_top.sv
sim/framed_packet_receiver_crc8_top_test.sv
